// ===== design/u8san_pkg.sv =====
// ----------------------------------------------------------------------------
// u8san_pkg
// Shared types, constants and byte classification helpers for the UTF-8
// sanitizer with output truncation.
// ----------------------------------------------------------------------------
package u8san_pkg;

   localparam int COUNT_BITS = 16;
   localparam int MAX_RESULTS = 4;

   localparam logic [7:0] QMARK      = 8'h3f;
   localparam logic [7:0] CTRL_TOP   = 8'h20;
   localparam logic [7:0] DEL_CHAR   = 8'h7f;
   localparam logic [7:0] ASCII_TOP  = 8'h80;
   localparam logic [7:0] LEAD2_LO   = 8'hc2;
   localparam logic [7:0] LEAD2_HI   = 8'hdf;
   localparam logic [7:0] LEAD3_LO   = 8'he0;
   localparam logic [7:0] LEAD3_HI   = 8'hef;
   localparam logic [7:0] LEAD4_LO   = 8'hf0;
   localparam logic [7:0] LEAD4_HI   = 8'hf4;
   localparam logic [7:0] LEAD_ED    = 8'hed;
   localparam logic [7:0] CONT_LO    = 8'h80;
   localparam logic [7:0] CONT_HI    = 8'hbf;
   localparam logic [7:0] E0_MIN     = 8'ha0;
   localparam logic [7:0] ED_MAX     = 8'h9f;
   localparam logic [7:0] F0_MIN     = 8'h90;
   localparam logic [7:0] F4_MAX     = 8'h8f;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       has_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
   } rsp_type;

   function automatic logic [2:0] seq_length(input logic [7:0] c);
      logic [2:0] len;
      len = 3'd0;
      if (c >= LEAD2_LO && c <= LEAD2_HI) begin
         len = 3'd2;
      end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
         len = 3'd3;
      end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
         len = 3'd4;
      end
      return len;
   endfunction

   function automatic logic is_cont(input logic [7:0] b);
      return (b >= CONT_LO) && (b <= CONT_HI);
   endfunction

   function automatic logic second_fits(input logic [7:0] lead, input logic [7:0] b);
      logic ok;
      ok = is_cont(b);
      if (lead == LEAD3_LO) begin
         ok = ok && (b >= E0_MIN);
      end else if (lead == LEAD_ED) begin
         ok = ok && (b <= ED_MAX);
      end else if (lead == LEAD4_LO) begin
         ok = ok && (b >= F0_MIN);
      end else if (lead == LEAD4_HI) begin
         ok = ok && (b <= F4_MAX);
      end
      return ok;
   endfunction

endpackage

// ===== design/utf8_sanitise_truncate_core.sv =====
// ----------------------------------------------------------------------------
// utf8_sanitise_truncate_core
// Streaming UTF-8 sanitizer that replaces control bytes and broken sequences
// with '?' and stops a message once its output capacity is used up.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  req     | in        | req_valid/req_ready  | req_data (req_type)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data (rsp_type)
//  csr     | in        | csr_valid/csr_ready  | csr_data (out_capacity)
//
// Each request beat is decoded in the cycle it is accepted and gives up to four
// response beats, held in a four-entry result register and sent one per cycle while rsp_ready is high.
// A new request is taken while the last response beat of the previous one is
// being taken, so a beat yielding at most one response sustains one per cycle while rsp_ready is high.
// Reset restores a capacity of 255 and clears the message state; pb_ff and buf_ff keep their values.
// ----------------------------------------------------------------------------
module utf8_sanitise_truncate_core
   import u8san_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic [15:0]           cap_ff;
   logic [7:0]            pb_ff [3];
   logic [1:0]            pc_ff;
   logic [2:0]            el_ff;
   logic [COUNT_BITS-1:0] emitted_ff;
   logic                  stop_ff;
   rsp_type               buf_ff [MAX_RESULTS];
   logic [2:0]            rem_ff;
   logic [1:0]            idx_ff;

   logic [7:0]            pb_in [3];
   logic [1:0]            pc_in;
   logic [2:0]            el_in;
   logic [COUNT_BITS-1:0] emitted_in;
   logic                  stop_in;
   rsp_type               res_in [MAX_RESULTS];
   logic [2:0]            n_in;
   logic [2:0]            used_in;

   logic [COUNT_BITS-1:0] limit;
   logic [COUNT_BITS-1:0] diff;
   logic [2:0]            room;
   logic [32:0]           cap_wide;
   logic [32:0]           cmax_wide;
   logic                  req_fire;
   logic                  rsp_fire;

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign rsp_valid = (rem_ff != 3'd0);
   assign rsp_data  = buf_ff[idx_ff];
   assign req_ready = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && rsp_ready);

   always_comb begin
      cap_wide  = 33'(cap_ff);
      cmax_wide = 33'({COUNT_BITS{1'b1}});
      limit     = COUNT_BITS'((cap_wide < cmax_wide) ? cap_wide : cmax_wide);
      diff      = limit - emitted_ff;
      if (emitted_ff >= limit) begin
         room = 3'd0;
      end else if (diff > COUNT_BITS'(4)) begin
         room = 3'd4;
      end else begin
         room = diff[2:0];
      end
   end

   always_comb begin
      logic [7:0] c;
      logic [1:0] fcount;
      logic       fresh;
      logic       ok;
      logic [2:0] len;
      c       = req_data.in_byte;
      fcount  = 2'd0;
      fresh   = 1'b0;
      ok      = 1'b0;
      len     = 3'd0;
      pb_in   = pb_ff;
      pc_in   = pc_ff;
      el_in   = el_ff;
      stop_in = stop_ff;
      n_in    = 3'd0;
      used_in = 3'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_in[i] = '{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b0};
      end

      if (req_data.has_byte && !stop_in) begin
         if (c == 8'h00) begin
            fcount = pc_in;
            pc_in  = 2'd0;
            el_in  = 3'd0;
            for (int k = 0; k < 3; k++) begin
               if (k < int'(fcount) && !stop_in) begin
                  if (used_in >= room) begin
                     stop_in = 1'b1;
                  end else begin
                     res_in[n_in[1:0]] = '{out_byte: QMARK, out_valid: 1'b1, out_last: 1'b0};
                     n_in    = n_in + 3'd1;
                     used_in = used_in + 3'd1;
                  end
               end
            end
            stop_in = 1'b1;
         end else if (pc_in == 2'd0) begin
            fresh = 1'b1;
         end else begin
            ok = (pc_in == 2'd1) ? second_fits(pb_in[0], c) : is_cont(c);
            if (!ok) begin
               fcount = pc_in;
               pc_in  = 2'd0;
               el_in  = 3'd0;
               for (int k = 0; k < 3; k++) begin
                  if (k < int'(fcount) && !stop_in) begin
                     if (used_in >= room) begin
                        stop_in = 1'b1;
                     end else begin
                        res_in[n_in[1:0]] = '{out_byte: QMARK, out_valid: 1'b1,
                                              out_last: 1'b0};
                        n_in    = n_in + 3'd1;
                        used_in = used_in + 3'd1;
                     end
                  end
               end
               fresh = 1'b1;
            end else if ((3'(pc_in) + 3'd1) < el_in) begin
               case (pc_in)
                  2'd1:    pb_in[1] = c;
                  default: pb_in[2] = c;
               endcase
               pc_in = pc_in + 2'd1;
            end else if (el_in > room) begin
               stop_in = 1'b1;
               pc_in   = 2'd0;
               el_in   = 3'd0;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  if (k < int'(pc_in)) begin
                     res_in[k] = '{out_byte: pb_in[k], out_valid: 1'b1, out_last: 1'b0};
                  end
               end
               res_in[pc_in] = '{out_byte: c, out_valid: 1'b1, out_last: 1'b0};
               n_in    = el_in;
               used_in = el_in;
               pc_in   = 2'd0;
               el_in   = 3'd0;
            end
         end

         if (fresh && !stop_in) begin
            len = seq_length(c);
            if (used_in >= room) begin
               stop_in = 1'b1;
               pc_in   = 2'd0;
               el_in   = 3'd0;
            end else if (c < CTRL_TOP || c == DEL_CHAR || (c >= ASCII_TOP && len == 3'd0)) begin
               res_in[n_in[1:0]] = '{out_byte: QMARK, out_valid: 1'b1, out_last: 1'b0};
               n_in    = n_in + 3'd1;
               used_in = used_in + 3'd1;
            end else if (c < ASCII_TOP) begin
               res_in[n_in[1:0]] = '{out_byte: c, out_valid: 1'b1, out_last: 1'b0};
               n_in    = n_in + 3'd1;
               used_in = used_in + 3'd1;
            end else begin
               pb_in[0] = c;
               pc_in    = 2'd1;
               el_in    = len;
            end
         end
      end

      emitted_in = emitted_ff + COUNT_BITS'(used_in);

      if (req_data.last) begin
         if (!stop_in) begin
            fcount = pc_in;
            pc_in  = 2'd0;
            el_in  = 3'd0;
            for (int k = 0; k < 3; k++) begin
               if (k < int'(fcount) && !stop_in) begin
                  if (used_in >= room) begin
                     stop_in = 1'b1;
                  end else begin
                     res_in[n_in[1:0]] = '{out_byte: QMARK, out_valid: 1'b1, out_last: 1'b0};
                     n_in    = n_in + 3'd1;
                     used_in = used_in + 3'd1;
                  end
               end
            end
         end
         if (n_in == 3'd0) begin
            res_in[0] = '{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b0};
            n_in      = 3'd1;
         end
         res_in[2'(n_in - 3'd1)].out_last = 1'b1;
         pc_in      = 2'd0;
         el_in      = 3'd0;
         stop_in    = 1'b0;
         emitted_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= 16'd255;
         pc_ff      <= 2'd0;
         el_ff      <= 3'd0;
         emitted_ff <= '0;
         stop_ff    <= 1'b0;
         rem_ff     <= 3'd0;
         idx_ff     <= 2'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         if (req_fire) begin
            pc_ff      <= pc_in;
            el_ff      <= el_in;
            emitted_ff <= emitted_in;
            stop_ff    <= stop_in;
            rem_ff     <= n_in;
            idx_ff     <= 2'd0;
         end else if (rsp_fire) begin
            rem_ff <= rem_ff - 3'd1;
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pb_ff <= pb_in;
         for (int i = 0; i < MAX_RESULTS; i++) begin
            buf_ff[i] <= res_in[i];
         end
      end
   end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sanitizer testbench
// Drives byte messages into utf8_sanitise_truncate_core, predicts every
// response beat with a behavioral copy of the sanitizer kept in this module,
// and compares the responses in order while both channels stall at random in most phases.
// The output capacity is changed between phases, zero and full scale included.
// ----------------------------------------------------------------------------
module testbench
   import u8san_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = 16'd255;

   utf8_sanitise_truncate_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sanitizer state as the stimulus sees it.
   logic [15:0]  capacity = 16'd255;
   logic [7:0]   held_bytes [3];
   int unsigned  held_count = 0;
   int unsigned  seq_bytes = 0;
   int unsigned  sent_count = 0;
   bit           halted = 1'b0;

   req_type      byte_queue [$];
   req_type      msg_buf [$];
   rsp_type      beat_out [$];
   rsp_type      expected_q [$];
   rsp_type      want;

   int           send_idle_pct = 14;
   int           recv_idle_pct = 83;
   int           accept_count = 0;
   int           drive_count = 0;
   int           fail_count = 0;
   int           item_count = 0;
   int           message_count = 0;
   int           beats_checked = 0;
   int           capacity_writes = 0;

   function automatic int unsigned byte_limit();
      longint unsigned top;
      top = (64'd1 << COUNT_BITS) - 1;
      return (capacity < top) ? int'(capacity) : int'(top);
   endfunction

   function automatic void halt_message();
      halted = 1'b1;
      held_count = 0;
      seq_bytes = 0;
   endfunction

   function automatic bit put_data(logic [7:0] b);
      rsp_type r;
      if (sent_count >= byte_limit()) begin
         halt_message();
         return 1'b0;
      end
      r.out_byte = b;
      r.out_valid = 1'b1;
      r.out_last = 1'b0;
      beat_out.push_back(r);
      sent_count++;
      return 1'b1;
   endfunction

   function automatic void dump_held();
      int unsigned n;
      n = held_count;
      held_count = 0;
      seq_bytes = 0;
      for (int unsigned k = 0; k < n; k++) begin
         if (!put_data(QMARK)) begin
            return;
         end
      end
   endfunction

   function automatic int unsigned lead_size(logic [7:0] c);
      if (c >= LEAD2_LO && c <= LEAD2_HI) begin
         return 2;
      end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
         return 3;
      end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
         return 4;
      end
      return 0;
   endfunction

   function automatic bit second_ok(logic [7:0] lead, logic [7:0] b);
      if (b < CONT_LO || b > CONT_HI) begin
         return 1'b0;
      end
      case (lead)
         LEAD3_LO: return b >= E0_MIN;
         LEAD_ED:  return b <= ED_MAX;
         LEAD4_LO: return b >= F0_MIN;
         LEAD4_HI: return b <= F4_MAX;
         default:  return 1'b1;
      endcase
   endfunction

   function automatic void start_fresh(logic [7:0] c);
      int unsigned n;
      if (halted) begin
         return;
      end
      if (sent_count >= byte_limit()) begin
         halt_message();
         return;
      end
      if (c < CTRL_TOP || c == DEL_CHAR) begin
         void'(put_data(QMARK));
      end else if (c < ASCII_TOP) begin
         void'(put_data(c));
      end else begin
         n = lead_size(c);
         if (n == 0) begin
            void'(put_data(QMARK));
         end else begin
            held_bytes[0] = c;
            held_count = 1;
            seq_bytes = n;
         end
      end
   endfunction

   function automatic void take_data(logic [7:0] c);
      bit ok;
      if (halted) begin
         return;
      end
      if (c == 8'h00) begin
         dump_held();
         halt_message();
         return;
      end
      if (held_count == 0) begin
         start_fresh(c);
         return;
      end
      if (held_count == 1) begin
         ok = second_ok(held_bytes[0], c);
      end else begin
         ok = (c >= CONT_LO && c <= CONT_HI);
      end
      if (!ok) begin
         dump_held();
         start_fresh(c);
         return;
      end
      if (held_count + 1 < seq_bytes) begin
         held_bytes[held_count] = c;
         held_count++;
         return;
      end
      if (longint'(sent_count) + seq_bytes > byte_limit()) begin
         halt_message();
         return;
      end
      for (int unsigned k = 0; k < held_count; k++) begin
         void'(put_data(held_bytes[k]));
      end
      void'(put_data(c));
      held_count = 0;
      seq_bytes = 0;
   endfunction

   function automatic void predict_beat(req_type q);
      rsp_type r;
      beat_out.delete();
      if (q.has_byte) begin
         take_data(q.in_byte);
      end
      if (q.last) begin
         if (!halted) begin
            dump_held();
         end
         if (beat_out.size() == 0) begin
            r = '0;
            beat_out.push_back(r);
         end
         r = beat_out.pop_back();
         r.out_last = 1'b1;
         beat_out.push_back(r);
         held_count = 0;
         seq_bytes = 0;
         sent_count = 0;
         halted = 1'b0;
      end
      foreach (beat_out[i]) begin
         expected_q.push_back(beat_out[i]);
      end
   endfunction

   // Accepted beats are predicted and responses checked at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_beat(req_data);
            accept_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected response beat: out_byte %02h out_valid %0b out_last %0b",
                      rsp_data.out_byte, rsp_data.out_valid, rsp_data.out_last);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               beats_checked++;
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_data.out_byte);
                  fail_count++;
               end
               if (rsp_data.out_valid !== want.out_valid) begin
                  $error("out_valid: expected %0b, got %0b", want.out_valid,
                         rsp_data.out_valid);
                  fail_count++;
               end
               if (rsp_data.out_last !== want.out_last) begin
                  $error("out_last: expected %0b, got %0b", want.out_last, rsp_data.out_last);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || accept_count == drive_count) begin
            if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= byte_queue.pop_front();
               req_valid <= 1'b1;
               drive_count++;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic push_item(logic [7:0] b, bit has, bit fin);
      req_type q;
      q.in_byte = b;
      q.has_byte = has;
      q.last = fin;
      byte_queue.push_back(q);
      if (has || fin) begin
         item_count++;
      end
      if (fin) begin
         message_count++;
      end
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (byte_queue.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_capacity(logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do begin
         @(posedge clock);
      end while (!(csr_valid && csr_ready));
      capacity = value;
      capacity_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic buf_byte(logic [7:0] b);
      req_type q;
      q.in_byte = b;
      q.has_byte = 1'b1;
      q.last = 1'b0;
      msg_buf.push_back(q);
   endtask

   // One multibyte character, whole or cut short, mostly within the narrow ranges.
   task automatic add_sequence(bit whole);
      int unsigned n;
      int unsigned keep;
      logic [7:0] lead;
      logic [7:0] second;
      n = $urandom_range(2, 4);
      case (n)
         2: lead = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
         3: begin
            case ($urandom_range(2))
               0: lead = LEAD3_LO;
               1: lead = LEAD_ED;
               default: lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
            endcase
         end
         default: begin
            case ($urandom_range(2))
               0: lead = LEAD4_LO;
               1: lead = LEAD4_HI;
               default: lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
            endcase
         end
      endcase
      if ($urandom_range(4) == 0) begin
         second = 8'($urandom_range(CONT_LO, CONT_HI));
      end else if (lead == LEAD3_LO) begin
         second = 8'($urandom_range(E0_MIN, CONT_HI));
      end else if (lead == LEAD_ED) begin
         second = 8'($urandom_range(CONT_LO, ED_MAX));
      end else if (lead == LEAD4_LO) begin
         second = 8'($urandom_range(F0_MIN, CONT_HI));
      end else if (lead == LEAD4_HI) begin
         second = 8'($urandom_range(CONT_LO, F4_MAX));
      end else begin
         second = 8'($urandom_range(CONT_LO, CONT_HI));
      end
      keep = whole ? n : $urandom_range(1, n - 1);
      buf_byte(lead);
      if (keep > 1) begin
         buf_byte(second);
      end
      for (int unsigned k = 2; k < keep; k++) begin
         buf_byte(8'($urandom_range(CONT_LO, CONT_HI)));
      end
   endtask

   task automatic random_messages(int target);
      int first;
      int chars;
      int pick;
      req_type q;
      first = item_count;
      while (item_count - first < target) begin
         msg_buf.delete();
         chars = $urandom_range(0, 10);
         for (int i = 0; i < chars; i++) begin
            pick = $urandom_range(99);
            if (pick < 33) begin
               buf_byte(8'($urandom_range(8'h20, 8'h7e)));
            end else if (pick < 39) begin
               buf_byte($urandom_range(1) ? DEL_CHAR : 8'($urandom_range(1, 31)));
            end else if (pick < 74) begin
               add_sequence(1'b1);
            end else if (pick < 84) begin
               add_sequence(1'b0);
            end else if (pick < 95) begin
               buf_byte(8'($urandom_range(1, 255)));
            end else if (pick < 97) begin
               buf_byte(8'h00);
            end else begin
               q.in_byte = 8'($urandom_range(255));
               q.has_byte = 1'b0;
               q.last = 1'b0;
               msg_buf.push_back(q);
            end
         end
         if (msg_buf.size() > 0 && msg_buf[$].has_byte && $urandom_range(1)) begin
            q = msg_buf.pop_back();
            q.last = 1'b1;
            msg_buf.push_back(q);
         end else begin
            q.in_byte = 8'($urandom_range(255));
            q.has_byte = 1'b0;
            q.last = 1'b1;
            msg_buf.push_back(q);
         end
         foreach (msg_buf[i]) begin
            push_item(msg_buf[i].in_byte, msg_buf[i].has_byte, msg_buf[i].last);
         end
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Printable and control bytes, two-byte extremes, bare end marker.
      push_item(8'h7e, 1'b1, 1'b0);
      push_item(8'h1f, 1'b1, 1'b0);
      push_item(DEL_CHAR, 1'b1, 1'b0);
      push_item(LEAD2_LO, 1'b1, 1'b0);
      push_item(CONT_LO, 1'b1, 1'b0);
      push_item(8'h00, 1'b0, 1'b1);
      // Narrow second-byte violations, then a complete four-byte character.
      push_item(LEAD3_LO, 1'b1, 1'b0);
      push_item(8'h9f, 1'b1, 1'b0);
      push_item(LEAD4_HI, 1'b1, 1'b0);
      push_item(8'h90, 1'b1, 1'b0);
      push_item(LEAD4_LO, 1'b1, 1'b0);
      push_item(F0_MIN, 1'b1, 1'b0);
      push_item(CONT_LO, 1'b1, 1'b0);
      push_item(CONT_HI, 1'b1, 1'b1);
      // An empty message.
      push_item(8'hff, 1'b0, 1'b1);
      // A marker that is ignored, then a NUL that cuts a pending sequence.
      push_item(8'h55, 1'b0, 1'b0);
      push_item(8'he1, 1'b1, 1'b0);
      push_item(CONT_LO, 1'b1, 1'b0);
      push_item(8'h00, 1'b1, 1'b1);
      // Invalid leads, a four-byte sequence broken by a control byte after three bytes, and
      // bytes still held when the message ends.
      push_item(8'hff, 1'b1, 1'b0);
      push_item(CONT_LO, 1'b1, 1'b0);
      push_item(8'hf1, 1'b1, 1'b0);
      push_item(CONT_LO, 1'b1, 1'b0);
      push_item(CONT_HI, 1'b1, 1'b0);
      push_item(8'h01, 1'b1, 1'b0);
      push_item(8'hf1, 1'b1, 1'b0);
      push_item(CONT_LO, 1'b1, 1'b1);
      wait_drained();

      write_capacity(16'd0);
      random_messages(15);
      wait_drained();
      write_capacity(16'hffff);
      random_messages(25);
      wait_drained();

      send_idle_pct = 83;
      recv_idle_pct = 14;
      write_capacity(16'd4);
      random_messages(20);
      wait_drained();
      random_messages(20);
      wait_drained();
      write_capacity(16'd1);
      random_messages(15);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_capacity(16'd9);
      random_messages(25);
      wait_drained();

      $display("Sent %0d items in %0d messages over %0d capacity settings.",
               item_count, message_count, capacity_writes + 1);
      $display("Checked %0d response beats against the prediction.", beats_checked);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d response beats outstanding.", expected_q.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
